FILE: rtl/lbg_pkg.sv
// lbg_pkg: shared types and constants for the led bar graph mapper
// no dependencies; imported by lbg_front, lbg_queue, lbg_back and the top level

package lbg_pkg;

	localparam int ONE_FX    = 16384;
	localparam int FX_SHIFT  = 14;
	localparam int LED_W     = 6;
	// unipolar step index, up to round(32767 * 193 / 16384) = 386
	localparam int IDX_W     = 9;
	// scaled bipolar magnitude, up to 3 * 32768 * 32 plus two third-steps
	localparam int MAG_W     = 23;
	localparam int UNI_PROD_W = 24;

	typedef struct packed {
		logic               bipolar;
		logic               neg;
		logic [IDX_W-1:0]   idx;
		logic [MAG_W-1:0]   m3;
	} lbg_item_t;

	typedef struct packed {
		logic push;
		logic pop;
	} lbg_q_ctrl_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} lbg_q_stat_t;

endpackage

FILE: rtl/lbg_front.sv
// lbg_front: accepts a display value and classifies it into a queue entry
// depends on lbg_pkg

module lbg_front #(
	parameter int NUM_LEDS = 33
) (
	input  logic                 start,
	input  logic                 q_full,
	input  logic signed [15:0]   value,
	input  logic                 bipolar,
	output logic                 busy,
	output logic                 push,
	output lbg_pkg::lbg_item_t   item
);
	import lbg_pkg::*;

	localparam int UNI_SCALE = 3 * NUM_LEDS + 1;
	localparam int BIP_SCALE = 3 * (NUM_LEDS / 2);

	logic                  val_pos;
	logic [UNI_PROD_W-1:0] uni_prod;
	logic [UNI_PROD_W-1:0] uni_round;
	logic [15:0]           mag;

	assign busy = q_full;
	assign push = start && !q_full;

	assign val_pos = !value[15] && (value != 16'sd0);

	// round half up is enough: non-positive values leave every led off
	assign uni_prod  = UNI_PROD_W'(value[14:0]) * UNI_PROD_W'(UNI_SCALE);
	assign uni_round = uni_prod + UNI_PROD_W'(ONE_FX / 2);

	// magnitude as unsigned, so the most negative value gives 32768
	assign mag = value[15] ? 16'(-value) : 16'(value);

	always_comb begin
		item.bipolar = bipolar;
		item.neg     = value[15];
		item.idx     = val_pos ? uni_round[FX_SHIFT +: IDX_W] : '0;
		item.m3      = MAG_W'(mag) * MAG_W'(BIP_SCALE);
	end

endmodule

FILE: rtl/lbg_queue.sv
// lbg_queue: two-entry queue between the front and the back end
// depends on lbg_pkg

module lbg_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lbg_pkg::lbg_q_ctrl_t ctrl,
	input  lbg_pkg::lbg_item_t   wr_item,
	output lbg_pkg::lbg_q_stat_t stat,
	output lbg_pkg::lbg_item_t   rd_item
);
	import lbg_pkg::*;

	lbg_item_t  mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign stat.full      = (count_q == 2'd2);
	assign stat.not_empty = (count_q != 2'd0);
	assign rd_item        = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (ctrl.push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (ctrl.pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (ctrl.push && !ctrl.pop) begin
				count_q <= count_q + 2'd1;
			end else if (ctrl.pop && !ctrl.push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

FILE: rtl/lbg_back.sv
// lbg_back: walks the leds of one queued value, one result per cycle
// depends on lbg_pkg

module lbg_back #(
	parameter int NUM_LEDS = 33
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_not_empty,
	input  lbg_pkg::lbg_item_t   q_item,
	output logic                 pop,
	output logic                 result_valid,
	output logic [5:0]           led_index,
	output logic [1:0]           brightness,
	output logic                 last_led
);
	import lbg_pkg::*;

	localparam logic [LED_W-1:0] CENTRE_IDX = LED_W'(NUM_LEDS / 2);
	localparam logic [LED_W-1:0] LAST_IDX   = LED_W'(NUM_LEDS - 1);

	logic             active_q;
	lbg_item_t        cur_q;
	logic [LED_W-1:0] i_q;
	logic             at_last;

	logic               result_valid_q;
	logic [LED_W-1:0]   led_index_q;
	logic [1:0]         brightness_q;
	logic               last_led_q;

	logic signed [IDX_W+1:0] uni_diff;
	logic [1:0]              uni_lvl;
	logic                    led_left;
	logic [LED_W-1:0]        led_dist;
	logic [MAG_W:0]          dist_scaled;
	logic [MAG_W:0]          th0;
	logic [MAG_W:0]          th1;
	logic [MAG_W:0]          th2;
	logic [1:0]              bip_lvl;
	logic [1:0]              level;

	assign at_last = (i_q == LAST_IDX);
	assign pop     = q_not_empty && (!active_q || at_last);

	// unipolar: clamp(idx - 3i - 1, 0, 3), first led at least dim when idx > 0
	always_comb begin
		uni_diff = $signed({2'b00, cur_q.idx})
			- $signed((IDX_W+2)'(3 * i_q) + (IDX_W+2)'(1));
		if (uni_diff < 0) begin
			uni_lvl = 2'd0;
		end else if (uni_diff > 3) begin
			uni_lvl = 2'd3;
		end else begin
			uni_lvl = uni_diff[1:0];
		end
		if ((i_q == '0) && (cur_q.idx != '0) && (uni_lvl == 2'd0)) begin
			uni_lvl = 2'd1;
		end
	end

	// bipolar: compare 3k*1.0 with 3|v|c plus zero, one or two third-steps
	always_comb begin
		led_left    = (i_q < CENTRE_IDX);
		led_dist    = led_left ? (CENTRE_IDX - i_q) : (i_q - CENTRE_IDX);
		dist_scaled = {(MAG_W+1-FX_SHIFT)'(led_dist * 3), FX_SHIFT'(0)};
		th0         = {1'b0, cur_q.m3};
		th1         = th0 + (MAG_W+1)'(ONE_FX);
		th2         = th0 + (MAG_W+1)'(2 * ONE_FX);
		if (i_q == CENTRE_IDX) begin
			bip_lvl = 2'd3;
		end else if (led_left != cur_q.neg) begin
			bip_lvl = 2'd0;
		end else if (dist_scaled <= th0) begin
			bip_lvl = 2'd3;
		end else if (dist_scaled <= th1) begin
			bip_lvl = 2'd2;
		end else if (dist_scaled <= th2) begin
			bip_lvl = 2'd1;
		end else begin
			bip_lvl = 2'd0;
		end
	end

	assign level = cur_q.bipolar ? bip_lvl : uni_lvl;

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_item;
		end
		led_index_q  <= i_q;
		brightness_q <= level;
		last_led_q   <= at_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q       <= 1'b0;
			i_q            <= '0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= active_q;
			if (pop) begin
				active_q <= 1'b1;
				i_q      <= '0;
			end else if (active_q) begin
				if (at_last) begin
					active_q <= 1'b0;
				end else begin
					i_q <= i_q + LED_W'(1);
				end
			end
		end
	end

	assign result_valid = result_valid_q;
	assign led_index    = led_index_q;
	assign brightness   = brightness_q;
	assign last_led     = last_led_q;

endmodule

FILE: rtl/led_bar_graph_mapper.sv
// led_bar_graph_mapper: maps a display value onto a bar of NUM_LEDS leds
// instantiates lbg_front, lbg_queue and lbg_back; depends on lbg_pkg
//
// A value (16384 = 1.0) and a mode flag transfer on a rising edge with start
// high and busy low. The block then emits NUM_LEDS results, led 0 first, one
// per cycle, each shown for exactly one cycle with result_valid high;
// last_led marks the final led of the bar. The receiver has no stall.
// When the back end is free, the first result of a value is registered
// after passing the queue entry and the back end's value register. The back
// end walks one led per cycle, so results of successive values follow
// without gaps while the next value waits in the queue. A two-entry queue
// lets start be taken while a bar is still being emitted; busy is high while
// both entries are held, so sustained input is paced by the back end.
// Reset empties the queue and idles the back end; no results are pending.

module led_bar_graph_mapper #(
	parameter int NUM_LEDS = 33
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] value,
	input  logic               bipolar,
	output logic               result_valid,
	output logic [5:0]         led_index,
	output logic [1:0]         brightness,
	output logic               last_led
);
	import lbg_pkg::*;

	lbg_item_t   front_item;
	lbg_item_t   queue_item;
	lbg_q_ctrl_t q_ctrl;
	lbg_q_stat_t q_stat;
	logic        push;
	logic        pop;

	assign q_ctrl.push = push;
	assign q_ctrl.pop  = pop;

	lbg_front #(
		.NUM_LEDS(NUM_LEDS)
	) u_front (
		.start  (start),
		.q_full (q_stat.full),
		.value  (value),
		.bipolar(bipolar),
		.busy   (busy),
		.push   (push),
		.item   (front_item)
	);

	lbg_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (q_ctrl),
		.wr_item(front_item),
		.stat   (q_stat),
		.rd_item(queue_item)
	);

	lbg_back #(
		.NUM_LEDS(NUM_LEDS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_stat.not_empty),
		.q_item      (queue_item),
		.pop         (pop),
		.result_valid(result_valid),
		.led_index   (led_index),
		.brightness  (brightness),
		.last_led    (last_led)
	);

endmodule
